### hw/rtl/rqv_pkg.sv
// Shared types, widths and constants of the rotated quad vertex generator.
package rqv_pkg;

   localparam int unsigned FRAC_BITS_DEF  = 16;
   localparam int unsigned TRIG_STEPS_DEF = 16;
   localparam int unsigned ATAN_COUNT     = 24;

   // CORDIC datapath: x/y in Q2.30 with headroom, z in 2^-32 turn
   localparam int unsigned XW = 33;
   localparam int unsigned ZW = 34;
   // clamped cosine/sine, Q2.30 in [-1.0, 1.0]
   localparam int unsigned CSW = 32;
   // rotation products and their Q2.30 shift
   localparam int unsigned PW        = 64;
   localparam int unsigned ROT_SHIFT = 30;
   localparam int unsigned RW        = PW - ROT_SHIFT;
   // scaled position plus origin
   localparam int unsigned BW = 33;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_CONTENT_SCALE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_VIEW_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_VIEW_HEIGHT = 3'd4;

   localparam logic [23:0] CONTENT_SCALE_RST = 24'd65536;
   localparam logic [31:0] INV_VIEW_RST      = 32'd4194304;

   localparam logic signed [XW-1:0]  CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [CSW-1:0] UNIT_POS    = 32'sd1073741824;
   localparam logic signed [CSW-1:0] UNIT_NEG    = -32'sd1073741824;

   // arctangent of 2^-i in units of 2^-32 turn
   localparam logic [29:0] ATAN_TABLE [ATAN_COUNT] = '{
      30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
      30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
      30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
      30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
   };

   typedef enum logic [1:0] {
      QUAD_0,
      QUAD_90,
      QUAD_180,
      QUAD_270
   } quad_type;

   typedef enum logic [1:0] {
      CORNER_LB,
      CORNER_RB,
      CORNER_RT,
      CORNER_LT
   } corner_type;

   typedef struct packed {
      logic [30:0]        size_x;
      logic [30:0]        size_y;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [15:0]        angle;
      logic [2:0]         tex_layer;
      logic [15:0]        tex_left;
      logic [15:0]        tex_top;
      logic [15:0]        tex_right;
      logic [15:0]        tex_bottom;
      logic [31:0]        rgba_color;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         corner_index;
      logic signed [31:0] vert_x;
      logic signed [31:0] vert_y;
      logic [15:0]        vert_u;
      logic [15:0]        vert_v;
      logic [31:0]        vert_color;
      logic [2:0]         vert_layer;
      logic               last_corner;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      quad_type             quad;
   } cordic_state_type;

   // one sprite, ready for corner expansion
   typedef struct packed {
      logic signed [PW-1:0] hc_x;   // half_x * cos
      logic signed [PW-1:0] hs_y;   // half_y * sin
      logic signed [PW-1:0] hs_x;   // half_x * sin
      logic signed [PW-1:0] hc_y;   // half_y * cos
      logic signed [BW-1:0] base_x;
      logic signed [BW-1:0] base_y;
      logic [15:0]          tex_left;
      logic [15:0]          tex_top;
      logic [15:0]          tex_right;
      logic [15:0]          tex_bottom;
      logic [31:0]          rgba_color;
      logic [2:0]           tex_layer;
   } quad_item_type;

endpackage

### hw/rtl/rqv_cordic_cell.sv
// One CORDIC rotation cell; carries the request alongside its x/y/z state.
module rqv_cordic_cell #(
   parameter int unsigned STAGE = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  rqv_pkg::cordic_state_type in_state,
   input  rqv_pkg::req_payload_type  in_req,
   output logic                     out_valid,
   output rqv_pkg::cordic_state_type out_state,
   output rqv_pkg::req_payload_type  out_req
);
   import rqv_pkg::*;

   localparam logic signed [ZW-1:0] ATAN_STEP = $signed({{(ZW-30){1'b0}}, ATAN_TABLE[STAGE]});

   logic                 valid_ff;
   cordic_state_type     state_ff;
   cordic_state_type     state_in;
   req_payload_type      req_ff;
   logic signed [XW-1:0] x_sh;
   logic signed [XW-1:0] y_sh;

   always_comb begin
      x_sh     = $signed(in_state.x) >>> STAGE;
      y_sh     = $signed(in_state.y) >>> STAGE;
      state_in = in_state;
      // rotate toward zero residual angle
      if (!in_state.z[ZW-1]) begin
         state_in.x = $signed(in_state.x) - y_sh;
         state_in.y = $signed(in_state.y) + x_sh;
         state_in.z = $signed(in_state.z) - ATAN_STEP;
      end else begin
         state_in.x = $signed(in_state.x) + y_sh;
         state_in.y = $signed(in_state.y) - x_sh;
         state_in.z = $signed(in_state.z) + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         state_ff <= state_in;
         req_ff   <= in_req;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
   assign out_req   = req_ff;

endmodule

### hw/rtl/rqv_vertex_unit.sv
// Corner sequencer and vertex pipeline: four vertices per sprite, one per cycle unless rsp_stall holds them.
module rqv_vertex_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load_valid,
   input  rqv_pkg::quad_item_type   load_item,
   output logic                     item_take,
   input  logic [31:0]              inv_view_width,
   input  logic [31:0]              inv_view_height,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rqv_pkg::rsp_payload_type rsp_payload
);
   import rqv_pkg::*;

   localparam int unsigned SW = RW + 1;     // corner + base
   localparam int unsigned MW = SW + 17;    // sum times 17-bit half reciprocal
   localparam int unsigned TW = MW + 1;

   typedef struct packed {
      corner_type  corner;
      logic        last;
      logic [15:0] u;
      logic [15:0] v;
      logic [31:0] color;
      logic [2:0]  layer;
   } side_type;

   // sequencer
   logic          seq_full_ff;
   logic          seq_full_in;
   corner_type    seq_cnt_ff;
   corner_type    seq_cnt_in;
   quad_item_type seq_item_ff;
   logic          ven;
   logic          emit;
   logic          seq_last;
   logic          is_right;
   logic          is_top;

   // V1: rotated corner offsets
   logic                 v1_valid_ff;
   logic signed [RW-1:0] v1_rx_ff;
   logic signed [RW-1:0] v1_ry_ff;
   logic signed [BW-1:0] v1_base_x_ff;
   logic signed [BW-1:0] v1_base_y_ff;
   side_type             v1_side_ff;
   side_type             v1_side_in;
   logic signed [PW-1:0] rot_x;
   logic signed [PW-1:0] rot_y;

   // V2: absolute coordinate
   logic                 v2_valid_ff;
   logic signed [SW-1:0] v2_sum_x_ff;
   logic signed [SW-1:0] v2_sum_y_ff;
   side_type             v2_side_ff;

   // V3: reciprocal partial products
   logic                 v3_valid_ff;
   logic signed [MW-1:0] v3_hi_x_ff;
   logic signed [MW-1:0] v3_lo_x_ff;
   logic signed [MW-1:0] v3_hi_y_ff;
   logic signed [MW-1:0] v3_lo_y_ff;
   side_type             v3_side_ff;

   // output register
   logic                 rsp_valid_ff;
   rsp_payload_type      rsp_payload_ff;
   rsp_payload_type      rsp_payload_in;
   logic signed [TW-1:0] norm_x;
   logic signed [TW-1:0] norm_y;

   // drop 16 fraction bits; the result fits when bits above bit 47 all match bit 47
   function automatic logic signed [31:0] sat_norm(input logic signed [TW-1:0] t);
      logic [TW-48:0] top_bits;
      top_bits = t[TW-1:47];
      if ((&top_bits) || !(|top_bits)) begin
         sat_norm = t[47:16];
      end else if (t[TW-1]) begin
         sat_norm = 32'sh80000000;
      end else begin
         sat_norm = 32'sh7fffffff;
      end
   endfunction

   assign ven       = !rsp_valid_ff || !rsp_stall;
   assign emit      = seq_full_ff && ven;
   assign seq_last  = (seq_cnt_ff == CORNER_LT);
   assign item_take = !seq_full_ff || (emit && seq_last);

   always_comb begin
      seq_full_in = item_take ? load_valid : seq_full_ff;
      if (item_take) begin
         seq_cnt_in = CORNER_LB;
      end else if (emit) begin
         seq_cnt_in = corner_type'(seq_cnt_ff + 2'd1);
      end else begin
         seq_cnt_in = seq_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_full_ff <= 1'b0;
         seq_cnt_ff  <= CORNER_LB;
      end else begin
         seq_full_ff <= seq_full_in;
         seq_cnt_ff  <= seq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         seq_item_ff <= load_item;
      end
   end

   // corner signs: right/top take the positive half extent
   always_comb begin
      is_right = (seq_cnt_ff == CORNER_RB) || (seq_cnt_ff == CORNER_RT);
      is_top   = (seq_cnt_ff == CORNER_RT) || (seq_cnt_ff == CORNER_LT);
      rot_x = (is_right ? seq_item_ff.hc_x : -seq_item_ff.hc_x)
            + (is_top ? -seq_item_ff.hs_y : seq_item_ff.hs_y);
      rot_y = (is_right ? seq_item_ff.hs_x : -seq_item_ff.hs_x)
            + (is_top ? seq_item_ff.hc_y : -seq_item_ff.hc_y);
      v1_side_in.corner = seq_cnt_ff;
      v1_side_in.last   = seq_last;
      v1_side_in.u      = is_right ? seq_item_ff.tex_right : seq_item_ff.tex_left;
      v1_side_in.v      = is_top ? seq_item_ff.tex_top : seq_item_ff.tex_bottom;
      v1_side_in.color  = seq_item_ff.rgba_color;
      v1_side_in.layer  = seq_item_ff.tex_layer;
   end

   always_comb begin
      norm_x = TW'(v3_hi_x_ff) + TW'(v3_lo_x_ff >>> 16);
      norm_y = TW'(v3_hi_y_ff) + TW'(v3_lo_y_ff >>> 16);
      rsp_payload_in.corner_index = v3_side_ff.corner;
      rsp_payload_in.vert_x       = sat_norm(norm_x);
      rsp_payload_in.vert_y       = sat_norm(norm_y);
      rsp_payload_in.vert_u       = v3_side_ff.u;
      rsp_payload_in.vert_v       = v3_side_ff.v;
      rsp_payload_in.vert_color   = v3_side_ff.color;
      rsp_payload_in.vert_layer   = v3_side_ff.layer;
      rsp_payload_in.last_corner  = v3_side_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_valid_ff  <= 1'b0;
         v2_valid_ff  <= 1'b0;
         v3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (ven) begin
         v1_valid_ff  <= seq_full_ff;
         v2_valid_ff  <= v1_valid_ff;
         v3_valid_ff  <= v2_valid_ff;
         rsp_valid_ff <= v3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ven) begin
         v1_rx_ff     <= rot_x[PW-1:ROT_SHIFT];
         v1_ry_ff     <= rot_y[PW-1:ROT_SHIFT];
         v1_base_x_ff <= seq_item_ff.base_x;
         v1_base_y_ff <= seq_item_ff.base_y;
         v1_side_ff   <= v1_side_in;

         v2_sum_x_ff <= SW'(v1_rx_ff) + SW'(v1_base_x_ff);
         v2_sum_y_ff <= SW'(v1_ry_ff) + SW'(v1_base_y_ff);
         v2_side_ff  <= v1_side_ff;

         v3_hi_x_ff <= MW'(v2_sum_x_ff) * MW'($signed({1'b0, inv_view_width[31:16]}));
         v3_lo_x_ff <= MW'(v2_sum_x_ff) * MW'($signed({1'b0, inv_view_width[15:0]}));
         v3_hi_y_ff <= MW'(v2_sum_y_ff) * MW'($signed({1'b0, inv_view_height[31:16]}));
         v3_lo_y_ff <= MW'(v2_sum_y_ff) * MW'($signed({1'b0, inv_view_height[15:0]}));
         v3_side_ff <= v2_side_ff;

         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      (emit && seq_cnt_ff == CORNER_LB) |=> (seq_full_ff && seq_cnt_ff == CORNER_RB))
      else $error("corner sequence skipped right-bottom");

   a_quad_release: assert property (@(posedge clock) disable iff (reset)
      (emit && seq_last && !load_valid) |=> !seq_full_ff)
      else $error("sprite slot not released after last corner");

   a_emit_enters: assert property (@(posedge clock) disable iff (reset)
      emit |=> v1_valid_ff)
      else $error("emitted corner lost at vertex pipeline entry");

endmodule

### hw/rtl/rotated_quad_vertex_gen_unit.sv
// Rotated sprite quad vertex generator: CORDIC cell chain, scaling stages, vertex unit.
//
// Usage:
//   req channel (req_valid/req_stall/req_payload) takes one sprite request: size, center,
//   angle, texture layer, texture rectangle and color. rsp channel returns four vertices
//   per request, in the order left-bottom, right-bottom, right-top, left-top; the fourth
//   carries last_corner. Configuration (content scale, origin, view reciprocals) is written
//   through csr_wr_en/csr_index/csr_wdata while the block is idle; unknown indexes are
//   dropped.
//   An accepted request passes through the CORDIC cells, the three scaling stages, the
//   corner slot and the four vertex stages before its first vertex shows on rsp_valid;
//   the other three follow on consecutive cycles unless rsp_stall holds them.
//   The vertex unit emits one corner per cycle on the result port unless rsp_stall holds
//   it. Requests advance through the cell chain only when the corner slot takes the next
//   sprite, so the chain holds while an earlier sprite is still being expanded.
//   Reset clears every valid bit and loads the configuration reset values.
//   When the receiver stalls a valid vertex, the whole vertex pipeline holds; once the corner slot is
//   busy the cell chain holds too and req_stall rises.
module rotated_quad_vertex_gen_unit #(
   parameter int unsigned FRAC_BITS  = rqv_pkg::FRAC_BITS_DEF,
   parameter int unsigned TRIG_STEPS = rqv_pkg::TRIG_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rqv_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rqv_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [rqv_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rqv_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rqv_pkg::*;

   localparam int unsigned STEPS = (TRIG_STEPS > ATAN_COUNT) ? ATAN_COUNT : TRIG_STEPS;
   localparam int unsigned HPW   = 31 + 24;   // size times scale
   localparam int unsigned PPW   = 32 + 25;   // signed position times scale
   localparam logic [30:0] HALF_MAX = 31'h7fffffff;
   localparam logic signed [PPW-1:0] S32_MAX = PPW'(32'sh7fffffff);
   localparam logic signed [PPW-1:0] S32_MIN = PPW'(32'sh80000000);
   localparam logic signed [XW:0]    UNIT_HI = (XW+1)'(UNIT_POS);
   localparam logic signed [XW:0]    UNIT_LO = (XW+1)'(UNIT_NEG);

   // configuration registers
   logic [23:0]        content_scale_ff;
   logic signed [31:0] origin_x_ff;
   logic signed [31:0] origin_y_ff;
   logic [31:0]        inv_view_width_ff;
   logic [31:0]        inv_view_height_ff;

   // front pipeline control
   logic front_adv;

   // angle fold into quadrant plus residual
   logic [15:0]      angle_bias;
   logic [15:0]      fold_resid;
   cordic_state_type seed;

   // cell chain; entry 0 is the folded request
   logic             chain_valid [STEPS+1];
   cordic_state_type chain_state [STEPS+1];
   req_payload_type  chain_req   [STEPS+1];

   // R1: unfolded cos/sin, scale products
   logic                  r1_valid_ff;
   logic signed [CSW-1:0] r1_cos_ff;
   logic signed [CSW-1:0] r1_sin_ff;
   logic signed [CSW-1:0] r1_cos_in;
   logic signed [CSW-1:0] r1_sin_in;
   logic [HPW-1:0]        r1_hprod_x_ff;
   logic [HPW-1:0]        r1_hprod_y_ff;
   logic signed [PPW-1:0] r1_pprod_x_ff;
   logic signed [PPW-1:0] r1_pprod_y_ff;
   req_payload_type       r1_req_ff;
   logic signed [XW:0]    cos_raw;
   logic signed [XW:0]    sin_raw;
   logic signed [XW:0]    cx_ext;
   logic signed [XW:0]    cy_ext;

   // R2: half extents and scaled position, saturated
   logic                  r2_valid_ff;
   logic [30:0]           r2_half_x_ff;
   logic [30:0]           r2_half_y_ff;
   logic [30:0]           r2_half_x_in;
   logic [30:0]           r2_half_y_in;
   logic signed [31:0]    r2_spos_x_ff;
   logic signed [31:0]    r2_spos_y_ff;
   logic signed [31:0]    r2_spos_x_in;
   logic signed [31:0]    r2_spos_y_in;
   logic signed [CSW-1:0] r2_cos_ff;
   logic signed [CSW-1:0] r2_sin_ff;
   req_payload_type       r2_req_ff;
   logic [HPW-1:0]        hsh_x;
   logic [HPW-1:0]        hsh_y;
   logic signed [PPW-1:0] psh_x;
   logic signed [PPW-1:0] psh_y;

   // R3: rotation products, sprite base
   logic          r3_valid_ff;
   quad_item_type r3_item_ff;
   quad_item_type r3_item_in;

   function automatic logic signed [CSW-1:0] clamp_unit(input logic signed [XW:0] v);
      if (v > UNIT_HI) begin
         clamp_unit = UNIT_POS;
      end else if (v < UNIT_LO) begin
         clamp_unit = UNIT_NEG;
      end else begin
         clamp_unit = v[CSW-1:0];
      end
   endfunction

   // ---------------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         content_scale_ff   <= CONTENT_SCALE_RST;
         origin_x_ff        <= '0;
         origin_y_ff        <= '0;
         inv_view_width_ff  <= INV_VIEW_RST;
         inv_view_height_ff <= INV_VIEW_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CONTENT_SCALE:   content_scale_ff   <= csr_wdata[23:0];
            CSR_ORIGIN_X:        origin_x_ff        <= $signed(csr_wdata);
            CSR_ORIGIN_Y:        origin_y_ff        <= $signed(csr_wdata);
            CSR_INV_VIEW_WIDTH:  inv_view_width_ff  <= csr_wdata;
            CSR_INV_VIEW_HEIGHT: inv_view_height_ff <= csr_wdata;
            default: ;   // drop writes to unmapped indexes
         endcase
      end
   end

   // ---------------------------------------------------------------- request entry
   assign req_stall = !front_adv;

   // Fold to the nearest quarter turn; the residual stays within one eighth turn
   // and is scaled to 2^-32 turn for the CORDIC z path.
   always_comb begin
      angle_bias = req_payload.angle + 16'h2000;
      seed.quad  = quad_type'(angle_bias[15:14]);
      fold_resid = req_payload.angle - {angle_bias[15:14], 14'd0};
      seed.x     = CORDIC_GAIN;
      seed.y     = '0;
      seed.z     = $signed({{(ZW-32){fold_resid[15]}}, fold_resid, 16'd0});
   end

   assign chain_valid[0] = req_valid;
   assign chain_state[0] = seed;
   assign chain_req[0]   = req_payload;

   // ---------------------------------------------------------------- CORDIC cell chain
   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      rqv_cordic_cell #(
         .STAGE (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (front_adv),
         .in_valid  (chain_valid[i]),
         .in_state  (chain_state[i]),
         .in_req    (chain_req[i]),
         .out_valid (chain_valid[i+1]),
         .out_state (chain_state[i+1]),
         .out_req   (chain_req[i+1])
      );
   end

   // ---------------------------------------------------------------- R1
   // Unfold the quadrant, clamp to +/-1.0; scale size and position in parallel.
   always_comb begin
      cx_ext = (XW+1)'(chain_state[STEPS].x);
      cy_ext = (XW+1)'(chain_state[STEPS].y);
      case (chain_state[STEPS].quad)
         QUAD_0: begin
            cos_raw = cx_ext;
            sin_raw = cy_ext;
         end
         QUAD_90: begin
            cos_raw = -cy_ext;
            sin_raw = cx_ext;
         end
         QUAD_180: begin
            cos_raw = -cx_ext;
            sin_raw = -cy_ext;
         end
         default: begin
            cos_raw = cy_ext;
            sin_raw = -cx_ext;
         end
      endcase
      r1_cos_in = clamp_unit(cos_raw);
      r1_sin_in = clamp_unit(sin_raw);
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         r1_cos_ff     <= r1_cos_in;
         r1_sin_ff     <= r1_sin_in;
         r1_hprod_x_ff <= HPW'(chain_req[STEPS].size_x) * HPW'(content_scale_ff);
         r1_hprod_y_ff <= HPW'(chain_req[STEPS].size_y) * HPW'(content_scale_ff);
         r1_pprod_x_ff <= PPW'(chain_req[STEPS].pos_x) * PPW'($signed({1'b0, content_scale_ff}));
         r1_pprod_y_ff <= PPW'(chain_req[STEPS].pos_y) * PPW'($signed({1'b0, content_scale_ff}));
         r1_req_ff     <= chain_req[STEPS];
      end
   end

   // ---------------------------------------------------------------- R2
   // Halve the size and drop fraction bits; saturate size to 31 bits, position to 32.
   always_comb begin
      hsh_x = r1_hprod_x_ff >> (FRAC_BITS + 1);
      hsh_y = r1_hprod_y_ff >> (FRAC_BITS + 1);
      psh_x = r1_pprod_x_ff >>> FRAC_BITS;
      psh_y = r1_pprod_y_ff >>> FRAC_BITS;
      r2_half_x_in = (hsh_x > HPW'(HALF_MAX)) ? HALF_MAX : hsh_x[30:0];
      r2_half_y_in = (hsh_y > HPW'(HALF_MAX)) ? HALF_MAX : hsh_y[30:0];
      if (psh_x > S32_MAX) begin
         r2_spos_x_in = 32'sh7fffffff;
      end else if (psh_x < S32_MIN) begin
         r2_spos_x_in = 32'sh80000000;
      end else begin
         r2_spos_x_in = psh_x[31:0];
      end
      if (psh_y > S32_MAX) begin
         r2_spos_y_in = 32'sh7fffffff;
      end else if (psh_y < S32_MIN) begin
         r2_spos_y_in = 32'sh80000000;
      end else begin
         r2_spos_y_in = psh_y[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         r2_half_x_ff <= r2_half_x_in;
         r2_half_y_ff <= r2_half_y_in;
         r2_spos_x_ff <= r2_spos_x_in;
         r2_spos_y_ff <= r2_spos_y_in;
         r2_cos_ff    <= r1_cos_ff;
         r2_sin_ff    <= r1_sin_ff;
         r2_req_ff    <= r1_req_ff;
      end
   end

   // ---------------------------------------------------------------- R3
   // Form the four half-extent products once; corners only flip their signs.
   always_comb begin
      r3_item_in.hc_x       = PW'($signed({1'b0, r2_half_x_ff})) * PW'(r2_cos_ff);
      r3_item_in.hs_y       = PW'($signed({1'b0, r2_half_y_ff})) * PW'(r2_sin_ff);
      r3_item_in.hs_x       = PW'($signed({1'b0, r2_half_x_ff})) * PW'(r2_sin_ff);
      r3_item_in.hc_y       = PW'($signed({1'b0, r2_half_y_ff})) * PW'(r2_cos_ff);
      r3_item_in.base_x     = BW'(r2_spos_x_ff) + BW'(origin_x_ff);
      r3_item_in.base_y     = BW'(r2_spos_y_ff) + BW'(origin_y_ff);
      r3_item_in.tex_left   = r2_req_ff.tex_left;
      r3_item_in.tex_top    = r2_req_ff.tex_top;
      r3_item_in.tex_right  = r2_req_ff.tex_right;
      r3_item_in.tex_bottom = r2_req_ff.tex_bottom;
      r3_item_in.rgba_color = r2_req_ff.rgba_color;
      r3_item_in.tex_layer  = r2_req_ff.tex_layer;
   end

   always_ff @(posedge clock) begin
      if (front_adv) begin
         r3_item_ff <= r3_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff <= 1'b0;
         r2_valid_ff <= 1'b0;
         r3_valid_ff <= 1'b0;
      end else if (front_adv) begin
         r1_valid_ff <= chain_valid[STEPS];
         r2_valid_ff <= r1_valid_ff;
         r3_valid_ff <= r2_valid_ff;
      end
   end

   // ---------------------------------------------------------------- vertex unit
   // Advance the front pipeline whenever the corner slot can take the next sprite.
   rqv_vertex_unit u_vertex (
      .clock           (clock),
      .reset           (reset),
      .load_valid      (r3_valid_ff),
      .load_item       (r3_item_ff),
      .item_take       (front_adv),
      .inv_view_width  (inv_view_width_ff),
      .inv_view_height (inv_view_height_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload)
   );

   a_req_enters_chain: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> chain_valid[1])
      else $error("accepted request missing from first CORDIC cell");

   a_sprite_held: assert property (@(posedge clock) disable iff (reset)
      (r3_valid_ff && !front_adv) |=> (r3_valid_ff && $stable(r3_item_ff)))
      else $error("sprite dropped or changed while corner slot busy");

endmodule
